/* rtl/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants of the timed command dispatch table
// Command, result kind and entry status codes, the stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_DELETE   = 3'd1;
    localparam logic [2:0] CMD_FLUSH    = 3'd2;
    localparam logic [2:0] CMD_TICK     = 3'd3;
    localparam logic [2:0] CMD_RESPONSE = 3'd4;
    localparam logic [2:0] CMD_LIST     = 3'd5;
    localparam logic [2:0] CMD_STATUS   = 3'd6;

    localparam logic [2:0] KIND_ACK      = 3'd0;
    localparam logic [2:0] KIND_DISPATCH = 3'd1;
    localparam logic [2:0] KIND_LIST     = 3'd2;
    localparam logic [2:0] KIND_LAST     = 3'd3;
    localparam logic [2:0] KIND_NEXT     = 3'd4;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_FLIGHT  = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic CFG_ENABLED  = 1'b0;
    localparam logic CFG_SCHED_ID = 1'b1;

    localparam logic [26:0] SEQ_LIMIT = 27'd100000000;

    typedef struct packed {
        logic [30:0] id;
        logic [47:0] due;
        logic [15:0] payload;
        logic [1:0]  status;
        logic [26:0] seq;
        logic [15:0] response;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/tcd_ram.sv */
// ----------------------------------------------------------------------------
// tcd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/timed_command_dispatch_table.sv */
// Add, delete and response scan the table, reading one entry at a time,
// then shift the entries that must move one by one (read, then write).
// Tick reads the next pending entry, gives the dispatch result, then scans
// onward for the next pending entry. Flush clears counts; list gives one result per entry.
// One command at a time; the table RAM single read port sets the pace.
// Reset clears counts and pointers at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
// timed_command_dispatch_table: time-ordered command scheduler
// Sorted entry table in RAM walked by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_command_dispatch_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [30:0] i_entry_id,
    input  wire logic [47:0] i_due_time,
    input  wire logic [15:0] i_payload,
    input  wire logic [47:0] i_now_time,
    input  wire logic [30:0] i_source_id,
    input  wire logic [26:0] i_seq_id,
    input  wire logic [15:0] i_response_handle,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic             o_ok,
    output logic [30:0]      o_out_entry_id,
    output logic [47:0]      o_out_due_time,
    output logic [15:0]      o_out_payload,
    output logic [26:0]      o_out_seq_id,
    output logic [1:0]       o_entry_state,
    output logic [15:0]      o_out_response,
    output logic [4:0]       o_total_count,
    output logic [4:0]       o_dispatched_count,
    output logic [4:0]       o_finished_count,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [30:0] i_cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(tcd_pkg::t_entry);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_RD    = 9'b000000100,
        S_EV    = 9'b000001000,
        S_SRD   = 9'b000010000,
        S_SWR   = 9'b000100000,
        S_PUT   = 9'b001000000,
        S_STAT2 = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state, r_after, n_after;

    logic [2:0]  r_cmd;
    logic [30:0] r_id, r_src;
    logic [47:0] r_due, r_now;
    logic [15:0] r_pay, r_resp;
    logic [26:0] r_seqin;

    logic          r_en, n_en;
    logic [30:0]   r_sid, n_sid;
    logic [CW-1:0] r_occ, n_occ, r_sent, n_sent, r_done, n_done;
    logic [CW-1:0] r_last, n_last, r_next, n_next;
    logic          r_lastv, n_lastv, r_nextv, n_nextv;
    logic [26:0]   r_seqc, n_seqc;

    logic [CW-1:0] r_idx, n_idx, r_pos, n_pos, r_q, n_q, r_cl, n_cl;
    logic [CW-1:0] r_cs, n_cs, r_cd, n_cd;
    logic          r_found, n_found, r_qv, n_qv, r_clv, n_clv;
    logic          r_phase, n_phase, r_ok, n_ok, r_has, n_has, r_lst, n_lst;
    logic [2:0]    r_kind, n_kind;
    tcd_pkg::t_entry r_ent, n_ent;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    tcd_pkg::t_entry ram_wdata, ram_rdata;
    logic [EW-1:0]   ram_rbits;

    logic out_free;

    assign out_free    = !o_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign ram_rdata   = tcd_pkg::t_entry'(ram_rbits);

    tcd_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    // read address: shift passes fetch the neighbour of the slot being written
    always_comb begin
        ram_raddr = r_idx[IW-1:0];
        if (r_state == S_SRD) begin
            if (r_cmd == tcd_pkg::CMD_ADD) begin
                ram_raddr = IW'(r_idx - CW'(1));
            end else begin
                ram_raddr = IW'(r_idx + CW'(1));
            end
        end
    end

    always_comb begin
        tcd_pkg::t_entry e;
        logic            hit, ahead, fin;
        logic [CW-1:0]   pos_v, newj, cs_v, cd_v, q_v, cl_v;
        logic            qv_v, clv_v, found_v;
        logic [26:0]     seq_inc;

        n_state = r_state;  n_after = r_after;
        n_en = r_en;  n_sid = r_sid;
        n_occ = r_occ;  n_sent = r_sent;  n_done = r_done;
        n_last = r_last;  n_lastv = r_lastv;  n_next = r_next;  n_nextv = r_nextv;
        n_seqc = r_seqc;
        n_idx = r_idx;  n_pos = r_pos;  n_q = r_q;  n_qv = r_qv;
        n_cl = r_cl;  n_clv = r_clv;  n_cs = r_cs;  n_cd = r_cd;
        n_found = r_found;  n_phase = r_phase;  n_ok = r_ok;
        n_has = r_has;  n_lst = r_lst;  n_kind = r_kind;  n_ent = r_ent;
        ram_we = 1'b0;  ram_waddr = r_idx[IW-1:0];  ram_wdata = ram_rdata;

        e       = ram_rdata;
        hit     = (e.id == r_id);
        ahead   = (e.due < r_due) || ((e.due == r_due) && (e.id < r_id));
        fin     = ((r_idx + CW'(1)) == r_occ);
        pos_v   = r_pos;  newj = r_idx;  cs_v = r_cs;  cd_v = r_cd;
        q_v     = r_q;  qv_v = r_qv;  cl_v = r_cl;  clv_v = r_clv;  found_v = r_found;
        seq_inc = r_seqc + 27'd1;

        if (i_cfg_valid) begin
            if (i_cfg_index == tcd_pkg::CFG_ENABLED) begin
                n_en = i_cfg_data[0];
            end else begin
                n_sid = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                // default result: a plain ack, ok clear
                n_kind = tcd_pkg::KIND_ACK;  n_ok = 1'b0;  n_has = 1'b0;  n_lst = 1'b1;
                n_after = S_IDLE;  n_state = S_OUT;
                n_idx = '0;  n_phase = 1'b0;  n_found = 1'b0;  n_qv = 1'b0;
                n_clv = 1'b0;  n_cs = '0;  n_cd = '0;  n_pos = r_occ;
                case (r_cmd)
                    tcd_pkg::CMD_ADD: begin
                        if (r_pay != '0 && r_id != '0 && r_due != '0 &&
                            r_occ < CW'(ENTRIES)) begin
                            n_state = (r_occ == '0) ? S_PUT : S_RD;
                        end
                    end
                    tcd_pkg::CMD_DELETE: begin
                        if (r_occ != '0) begin
                            n_state = S_RD;
                        end
                    end
                    tcd_pkg::CMD_FLUSH: begin
                        n_occ = '0;  n_sent = '0;  n_done = '0;
                        n_lastv = 1'b0;  n_last = '0;  n_nextv = 1'b0;  n_next = '0;
                        n_ok = 1'b1;
                    end
                    tcd_pkg::CMD_TICK: begin
                        if (r_en && r_nextv) begin
                            n_idx = r_next;  n_state = S_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    tcd_pkg::CMD_RESPONSE: begin
                        if (r_src == r_sid) begin
                            if (r_lastv) begin
                                n_idx = r_last;  n_state = S_RD;
                            end else if (r_occ != '0) begin
                                n_phase = 1'b1;  n_state = S_RD;
                            end
                        end
                    end
                    tcd_pkg::CMD_LIST: begin
                        n_kind = tcd_pkg::KIND_LIST;
                        if (r_occ != '0) begin
                            n_state = S_RD;
                        end
                    end
                    tcd_pkg::CMD_STATUS: begin
                        if (r_lastv) begin
                            n_idx = r_last;  n_state = S_RD;
                        end else begin
                            n_kind = tcd_pkg::KIND_LAST;  n_lst = 1'b0;  n_after = S_STAT2;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_RD: begin
                n_state = S_EV;
            end

            S_EV: begin
                case (r_cmd)
                    tcd_pkg::CMD_ADD: begin
                        found_v = r_found | hit;
                        if (!ahead && r_pos == r_occ) begin
                            pos_v = r_idx;
                        end
                        if (!r_qv && e.status == tcd_pkg::ST_PENDING) begin
                            q_v = r_idx;  qv_v = 1'b1;
                        end
                        n_found = found_v;  n_pos = pos_v;  n_q = q_v;  n_qv = qv_v;
                        if (fin) begin
                            if (found_v) begin
                                n_state = S_OUT;
                            end else begin
                                n_idx = r_occ;
                                n_state = (r_occ > pos_v) ? S_SRD : S_PUT;
                            end
                        end else begin
                            n_idx = r_idx + CW'(1);  n_state = S_RD;
                        end
                    end
                    tcd_pkg::CMD_DELETE: begin
                        // recount over the table as it stands after removal
                        if (!r_found && hit) begin
                            found_v = 1'b1;  pos_v = r_idx;
                        end else begin
                            newj = r_found ? (r_idx - CW'(1)) : r_idx;
                            if (e.status != tcd_pkg::ST_PENDING) begin
                                cs_v = r_cs + CW'(1);  cl_v = newj;  clv_v = 1'b1;
                            end else if (!r_qv) begin
                                q_v = newj;  qv_v = 1'b1;
                            end
                            if (e.status == tcd_pkg::ST_DONE) begin
                                cd_v = r_cd + CW'(1);
                            end
                        end
                        n_found = found_v;  n_pos = pos_v;  n_cs = cs_v;  n_cd = cd_v;
                        n_q = q_v;  n_qv = qv_v;  n_cl = cl_v;  n_clv = clv_v;
                        if (fin) begin
                            if (!found_v) begin
                                n_state = S_OUT;
                            end else begin
                                n_sent = cs_v;  n_done = cd_v;
                                n_last = clv_v ? cl_v : '0;  n_lastv = clv_v;
                                n_next = qv_v ? q_v : '0;  n_nextv = qv_v;
                                n_ok = 1'b1;
                                if ((pos_v + CW'(1)) < r_occ) begin
                                    n_idx = pos_v;  n_state = S_SRD;
                                end else begin
                                    n_occ = r_occ - CW'(1);  n_state = S_OUT;
                                end
                            end
                        end else begin
                            n_idx = r_idx + CW'(1);  n_state = S_RD;
                        end
                    end
                    tcd_pkg::CMD_TICK: begin
                        if (!r_phase) begin
                            if (e.due > r_now) begin
                                n_state = S_IDLE;
                            end else begin
                                n_ent = e;
                                n_ent.status = tcd_pkg::ST_FLIGHT;
                                n_ent.seq = r_seqc;
                                ram_we = 1'b1;  ram_wdata = n_ent;
                                n_seqc = (seq_inc > tcd_pkg::SEQ_LIMIT) ? '0 : seq_inc;
                                n_last = r_idx;  n_lastv = 1'b1;
                                n_sent = r_sent + CW'(1);
                                n_nextv = 1'b0;  n_next = '0;
                                n_kind = tcd_pkg::KIND_DISPATCH;  n_ok = 1'b1;
                                n_has = 1'b1;  n_lst = 1'b1;  n_state = S_OUT;
                                // search onward for the next pending entry
                                n_phase = 1'b1;  n_idx = r_idx + CW'(1);
                                n_after = fin ? S_IDLE : S_RD;
                            end
                        end else begin
                            if (e.status == tcd_pkg::ST_PENDING) begin
                                n_next = r_idx;  n_nextv = 1'b1;  n_state = S_IDLE;
                            end else if (fin) begin
                                n_state = S_IDLE;
                            end else begin
                                n_idx = r_idx + CW'(1);  n_state = S_RD;
                            end
                        end
                    end
                    tcd_pkg::CMD_RESPONSE: begin
                        if (e.status == tcd_pkg::ST_FLIGHT && e.seq == r_seqin) begin
                            n_ent = e;
                            n_ent.status = tcd_pkg::ST_DONE;
                            n_ent.response = r_resp;
                            ram_we = 1'b1;  ram_wdata = n_ent;
                            n_done = r_done + CW'(1);
                            n_ok = 1'b1;
                        end
                        if (!r_phase) begin
                            if (e.status == tcd_pkg::ST_FLIGHT && e.seq == r_seqin) begin
                                n_has = 1'b1;  n_state = S_OUT;
                            end else begin
                                n_phase = 1'b1;  n_idx = '0;  n_state = S_RD;
                            end
                        end else if (fin) begin
                            n_state = S_OUT;
                        end else begin
                            n_idx = r_idx + CW'(1);  n_state = S_RD;
                        end
                    end
                    tcd_pkg::CMD_LIST: begin
                        n_ent = e;  n_ok = 1'b1;  n_has = 1'b1;  n_lst = fin;
                        n_after = fin ? S_IDLE : S_RD;
                        n_idx = r_idx + CW'(1);  n_state = S_OUT;
                    end
                    default: begin
                        // status reports
                        n_ent = e;  n_ok = 1'b1;  n_has = 1'b1;  n_state = S_OUT;
                        if (!r_phase) begin
                            n_kind = tcd_pkg::KIND_LAST;  n_lst = 1'b0;  n_after = S_STAT2;
                        end else begin
                            n_kind = tcd_pkg::KIND_NEXT;  n_lst = 1'b1;  n_after = S_IDLE;
                        end
                    end
                endcase
            end

            S_SRD: begin
                n_state = S_SWR;
            end

            S_SWR: begin
                ram_we = 1'b1;  ram_wdata = ram_rdata;
                if (r_cmd == tcd_pkg::CMD_ADD) begin
                    n_idx = r_idx - CW'(1);
                    n_state = ((r_idx - CW'(1)) > r_pos) ? S_SRD : S_PUT;
                end else begin
                    n_idx = r_idx + CW'(1);
                    if ((r_idx + CW'(2)) < r_occ) begin
                        n_state = S_SRD;
                    end else begin
                        n_occ = r_occ - CW'(1);  n_state = S_OUT;
                    end
                end
            end

            S_PUT: begin
                ram_we = 1'b1;  ram_waddr = r_pos[IW-1:0];
                ram_wdata.id = r_id;  ram_wdata.due = r_due;  ram_wdata.payload = r_pay;
                ram_wdata.status = tcd_pkg::ST_PENDING;
                ram_wdata.seq = '0;  ram_wdata.response = '0;
                n_occ = r_occ + CW'(1);
                if (r_lastv && r_last >= r_pos) begin
                    n_last = r_last + CW'(1);
                end
                n_nextv = 1'b1;
                n_next = (r_qv && r_q < r_pos) ? r_q : r_pos;
                n_ok = 1'b1;  n_state = S_OUT;
            end

            S_STAT2: begin
                n_phase = 1'b1;
                if (r_nextv) begin
                    n_idx = r_next;  n_state = S_RD;
                end else begin
                    n_kind = tcd_pkg::KIND_NEXT;  n_ok = 1'b0;  n_has = 1'b0;
                    n_lst = 1'b1;  n_after = S_IDLE;  n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (out_free) begin
                    n_state = r_after;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_after <= S_IDLE;
            r_en <= 1'b0;  r_sid <= '0;
            r_occ <= '0;  r_sent <= '0;  r_done <= '0;
            r_last <= '0;  r_lastv <= 1'b0;  r_next <= '0;  r_nextv <= 1'b0;
            r_seqc <= 27'd1;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;  r_after <= n_after;
            r_en <= n_en;  r_sid <= n_sid;
            r_occ <= n_occ;  r_sent <= n_sent;  r_done <= n_done;
            r_last <= n_last;  r_lastv <= n_lastv;  r_next <= n_next;  r_nextv <= n_nextv;
            r_seqc <= n_seqc;
            if (r_state == S_OUT && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload and scan working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd <= i_command;  r_id <= i_entry_id;  r_due <= i_due_time;
            r_pay <= i_payload;  r_now <= i_now_time;  r_src <= i_source_id;
            r_seqin <= i_seq_id;  r_resp <= i_response_handle;
        end
        r_idx <= n_idx;  r_pos <= n_pos;  r_q <= n_q;  r_qv <= n_qv;
        r_cl <= n_cl;  r_clv <= n_clv;  r_cs <= n_cs;  r_cd <= n_cd;
        r_found <= n_found;  r_phase <= n_phase;  r_ok <= n_ok;
        r_has <= n_has;  r_lst <= n_lst;  r_kind <= n_kind;  r_ent <= n_ent;
        if (r_state == S_OUT && out_free) begin
            o_kind <= r_kind;  o_ok <= r_ok;  o_last <= r_lst;
            o_out_entry_id <= r_has ? r_ent.id : '0;
            o_out_due_time <= r_has ? r_ent.due : '0;
            o_out_payload  <= r_has ? r_ent.payload : '0;
            o_out_seq_id   <= r_has ? r_ent.seq : '0;
            o_entry_state  <= r_has ? r_ent.status : '0;
            o_out_response <= r_has ? r_ent.response : '0;
            o_total_count      <= 5'(r_occ);
            o_dispatched_count <= 5'(r_sent);
            o_finished_count   <= 5'(r_done);
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(ENTRIES)) else $error("entry count beyond table size");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done <= r_sent) && (r_sent <= r_occ))
        else $error("finished, dispatched and total counts out of order");

    a_next_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nextv |-> (r_next < r_occ)) else $error("next entry outside table");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> o_stall)
        else $error("new transfer taken while a command is in progress");

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the timed command dispatch table
// Drives commands and register writes, keeps its own copy of the sorted
// table to predict every result, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [2:0]  command;
        logic [30:0] entry_id;
        logic [47:0] due_time;
        logic [15:0] payload;
        logic [47:0] now_time;
        logic [30:0] source_id;
        logic [26:0] seq_id;
        logic [15:0] response_handle;
    } t_cmd;

    typedef struct {
        logic [2:0]  kind;
        logic        ok;
        logic [30:0] entry_id;
        logic [47:0] due_time;
        logic [15:0] payload;
        logic [26:0] seq_id;
        logic [1:0]  entry_state;
        logic [15:0] response;
        logic [4:0]  total;
        logic [4:0]  dispatched;
        logic [4:0]  finished;
        logic        last;
    } t_result;

    localparam int ENTRIES = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;

    class dispatch_scoreboard;
        tcd_pkg::t_entry tbl [ENTRIES];
        int          occ;
        int          sent;
        int          done;
        bit          last_v;
        int          last_s;
        bit          next_v;
        int          next_s;
        logic [26:0] seq_ctr;
        bit          en;
        logic [30:0] sid;
        t_result     expq [$];

        function void reset_state();
            occ = 0; sent = 0; done = 0;
            last_v = 0; last_s = 0; next_v = 0; next_s = 0;
            seq_ctr = 27'd1; en = 0; sid = '0;
            expq.delete();
        endfunction

        function void write_reg(logic idx, logic [30:0] data);
            if (idx == tcd_pkg::CFG_ENABLED) en = data[0];
            else sid = data;
        endfunction

        function void find_next();
            next_v = 0;
            next_s = 0;
            for (int i = 0; i < occ; i++) begin
                if (tbl[i].status == tcd_pkg::ST_PENDING) begin
                    next_v = 1;
                    next_s = i;
                    return;
                end
            end
        endfunction

        function void push(logic [2:0] kind, logic ok, bit has, int s, logic last);
            t_result r;
            r = '{default: '0};
            r.kind = kind;
            r.ok = ok;
            if (has) begin
                r.entry_id = tbl[s].id;
                r.due_time = tbl[s].due;
                r.payload = tbl[s].payload;
                r.seq_id = tbl[s].seq;
                r.entry_state = tbl[s].status;
                r.response = tbl[s].response;
            end
            r.total = occ[4:0];
            r.dispatched = sent[4:0];
            r.finished = done[4:0];
            r.last = last;
            expq.insert(expq.size(), r);
        endfunction

        function bit add_entry(t_cmd c);
            int p;
            if (c.payload == 0 || c.entry_id == 0 || c.due_time == 0 || occ >= ENTRIES)
                return 0;
            for (int i = 0; i < occ; i++)
                if (tbl[i].id == c.entry_id) return 0;
            p = 0;
            while (p < occ && (tbl[p].due < c.due_time ||
                   (tbl[p].due == c.due_time && tbl[p].id < c.entry_id)))
                p++;
            for (int i = occ; i > p; i--) tbl[i] = tbl[i-1];
            tbl[p] = '{c.entry_id, c.due_time, c.payload, tcd_pkg::ST_PENDING,
                       27'd0, 16'd0};
            occ++;
            if (last_v && last_s >= p) last_s++;
            find_next();
            return 1;
        endfunction

        function bit delete_entry(logic [30:0] id);
            int p;
            p = 0;
            while (p < occ && tbl[p].id != id) p++;
            if (p >= occ) return 0;
            for (int i = p; i + 1 < occ; i++) tbl[i] = tbl[i+1];
            occ--;
            last_v = 0; last_s = 0; sent = 0; done = 0;
            for (int i = 0; i < occ; i++) begin
                if (tbl[i].status != tcd_pkg::ST_PENDING) begin
                    sent++;
                    last_v = 1;
                    last_s = i;
                end
                if (tbl[i].status == tcd_pkg::ST_DONE) done++;
            end
            find_next();
            return 1;
        endfunction

        function void note_input(t_cmd c);
            bit ok;
            int s;
            case (c.command)
                tcd_pkg::CMD_ADD: begin
                    ok = add_entry(c);
                    push(tcd_pkg::KIND_ACK, ok, 1'b0, 0, 1'b1);
                end
                tcd_pkg::CMD_DELETE: begin
                    ok = delete_entry(c.entry_id);
                    push(tcd_pkg::KIND_ACK, ok, 1'b0, 0, 1'b1);
                end
                tcd_pkg::CMD_FLUSH: begin
                    occ = 0; sent = 0; done = 0;
                    last_v = 0; last_s = 0; next_v = 0; next_s = 0;
                    push(tcd_pkg::KIND_ACK, 1'b1, 1'b0, 0, 1'b1);
                end
                tcd_pkg::CMD_TICK: begin
                    if (en && next_v && tbl[next_s].due <= c.now_time) begin
                        s = next_s;
                        tbl[s].seq = seq_ctr;
                        seq_ctr++;
                        if (seq_ctr > tcd_pkg::SEQ_LIMIT) seq_ctr = '0;
                        tbl[s].status = tcd_pkg::ST_FLIGHT;
                        last_v = 1;
                        last_s = s;
                        sent++;
                        find_next();
                        push(tcd_pkg::KIND_DISPATCH, 1'b1, 1'b1, s, 1'b1);
                    end
                end
                tcd_pkg::CMD_RESPONSE: begin
                    if (c.source_id != sid) begin
                        push(tcd_pkg::KIND_ACK, 1'b0, 1'b0, 0, 1'b1);
                    end else if (last_v && last_s < occ &&
                                 tbl[last_s].status == tcd_pkg::ST_FLIGHT &&
                                 tbl[last_s].seq == c.seq_id) begin
                        tbl[last_s].response = c.response_handle;
                        tbl[last_s].status = tcd_pkg::ST_DONE;
                        done++;
                        push(tcd_pkg::KIND_ACK, 1'b1, 1'b1, last_s, 1'b1);
                    end else begin
                        ok = 0;
                        for (int i = 0; i < occ; i++) begin
                            if (tbl[i].status == tcd_pkg::ST_FLIGHT &&
                                tbl[i].seq == c.seq_id) begin
                                tbl[i].response = c.response_handle;
                                tbl[i].status = tcd_pkg::ST_DONE;
                                done++;
                                ok = 1;
                            end
                        end
                        push(tcd_pkg::KIND_ACK, ok, 1'b0, 0, 1'b1);
                    end
                end
                tcd_pkg::CMD_LIST: begin
                    if (occ == 0) push(tcd_pkg::KIND_LIST, 1'b0, 1'b0, 0, 1'b1);
                    for (int k = 0; k < occ; k++)
                        push(tcd_pkg::KIND_LIST, 1'b1, 1'b1, k, k + 1 == occ);
                end
                tcd_pkg::CMD_STATUS: begin
                    push(tcd_pkg::KIND_LAST, last_v, last_v, last_s, 1'b0);
                    push(tcd_pkg::KIND_NEXT, next_v, next_v, next_s, 1'b1);
                end
                default: push(tcd_pkg::KIND_ACK, 1'b0, 1'b0, 0, 1'b1);
            endcase
        endfunction

        function string check(t_result got);
            t_result e;
            string m;
            if (expq.size() == 0) return "result transfer with nothing expected";
            e = expq.pop_front();
            m = "";
            if (got.kind !== e.kind) m = {m, " kind"};
            if (got.ok !== e.ok) m = {m, " ok"};
            if (got.entry_id !== e.entry_id) m = {m, " entry_id"};
            if (got.due_time !== e.due_time) m = {m, " due_time"};
            if (got.payload !== e.payload) m = {m, " payload"};
            if (got.seq_id !== e.seq_id) m = {m, " seq_id"};
            if (got.entry_state !== e.entry_state) m = {m, " entry_state"};
            if (got.response !== e.response) m = {m, " response"};
            if (got.total !== e.total) m = {m, " total_count"};
            if (got.dispatched !== e.dispatched) m = {m, " dispatched_count"};
            if (got.finished !== e.finished) m = {m, " finished_count"};
            if (got.last !== e.last) m = {m, " last"};
            if (m == "") return "";
            return $sformatf("kind %0d id %0d: wrong%s", e.kind, e.entry_id, m);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_command;
    logic [30:0] i_entry_id;
    logic [47:0] i_due_time;
    logic [15:0] i_payload;
    logic [47:0] i_now_time;
    logic [30:0] i_source_id;
    logic [26:0] i_seq_id;
    logic [15:0] i_response_handle;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic        o_ok;
    logic [30:0] o_out_entry_id;
    logic [47:0] o_out_due_time;
    logic [15:0] o_out_payload;
    logic [26:0] o_out_seq_id;
    logic [1:0]  o_entry_state;
    logic [15:0] o_out_response;
    logic [4:0]  o_total_count;
    logic [4:0]  o_dispatched_count;
    logic [4:0]  o_finished_count;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [30:0] i_cfg_data;

    timed_command_dispatch_table #(.ENTRIES(ENTRIES)) dut (.*);

    dispatch_scoreboard sb = new();
    int  errors = 0;
    int  idle_cycles = 0;
    bit  tx_quiet = 0;
    bit  rx_quiet = 0;
    bit  hold_go = 0;
    int  hold_left = 0;
    int  stall_run = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stall runs, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_go) begin
            hold_go = 0;
            hold_left = 300;
            i_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            i_stall <= ($urandom_range(0, 99) >= 60);
            stall_run = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result r;
        string   msg;
        if (i_rst_n && o_valid && !i_stall) begin
            r = '{o_kind, o_ok, o_out_entry_id, o_out_due_time, o_out_payload,
                  o_out_seq_id, o_entry_state, o_out_response, o_total_count,
                  o_dispatched_count, o_finished_count, o_last};
            msg = sb.check(r);
            if (msg != "") report(msg);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(t_cmd c);
        i_valid = 1'b1;
        i_command = c.command;
        i_entry_id = c.entry_id;
        i_due_time = c.due_time;
        i_payload = c.payload;
        i_now_time = c.now_time;
        i_source_id = c.source_id;
        i_seq_id = c.seq_id;
        i_response_handle = c.response_handle;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(c);
        @(negedge i_clk);
        i_valid = 1'b0;
        if (!tx_quiet) repeat (pick_gap()) @(negedge i_clk);
    endtask

    task automatic cmd(logic [2:0] op, logic [30:0] id = '0, logic [47:0] due = '0,
                       logic [15:0] pay = '0, logic [47:0] now = '0,
                       logic [30:0] src = '0, logic [26:0] seq = '0,
                       logic [15:0] resp = '0);
        t_cmd c;
        c = '{op, id, due, pay, now, src, seq, resp};
        send(c);
    endtask

    task automatic write_reg(logic idx, logic [30:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait out every expected result, then the longest silent command
    task automatic drain();
        while (sb.expq.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [26:0] flight_seq();
        for (int i = 0; i < sb.occ; i++)
            if (sb.tbl[i].status == tcd_pkg::ST_FLIGHT) return sb.tbl[i].seq;
        return sb.seq_ctr - 27'd1;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   r;
        c.command = 3'($urandom_range(0, 7));
        c.entry_id = 31'($urandom);
        c.due_time = 48'({$urandom, $urandom});
        c.payload = 16'($urandom);
        c.now_time = 48'({$urandom, $urandom});
        c.source_id = 31'($urandom);
        c.seq_id = 27'($urandom_range(0, 100000000));
        c.response_handle = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30) begin
            c.command = tcd_pkg::CMD_ADD;
            if ($urandom_range(0, 99) < 85) c.entry_id = 31'($urandom_range(1, 40));
            if ($urandom_range(0, 99) < 85) c.due_time = 48'($urandom_range(1, 200));
            if ($urandom_range(0, 99) < 5) c.payload = '0;
            if ($urandom_range(0, 99) < 3) c.entry_id = '0;
            if ($urandom_range(0, 99) < 3) c.due_time = '0;
            if (sb.occ > 0 && $urandom_range(0, 99) < 8)
                c.entry_id = sb.tbl[$urandom_range(0, sb.occ - 1)].id;
        end else if (r < 40) begin
            c.command = tcd_pkg::CMD_DELETE;
            if (sb.occ > 0 && $urandom_range(0, 99) < 75)
                c.entry_id = sb.tbl[$urandom_range(0, sb.occ - 1)].id;
        end else if (r < 43) begin
            c.command = tcd_pkg::CMD_FLUSH;
        end else if (r < 65) begin
            c.command = tcd_pkg::CMD_TICK;
            if ($urandom_range(0, 99) < 80) c.now_time = 48'($urandom_range(0, 250));
        end else if (r < 82) begin
            c.command = tcd_pkg::CMD_RESPONSE;
            if ($urandom_range(0, 99) < 85) c.source_id = sb.sid;
            if ($urandom_range(0, 99) < 80) c.seq_id = flight_seq();
        end else if (r < 90) begin
            c.command = tcd_pkg::CMD_LIST;
        end else if (r < 97) begin
            c.command = tcd_pkg::CMD_STATUS;
        end
        return c;
    endfunction

    task automatic random_phase(bit en, logic [30:0] id, int count, bit pressure);
        write_reg(tcd_pkg::CFG_ENABLED, {30'($urandom), en});
        write_reg(tcd_pkg::CFG_SCHED_ID, id);
        for (int n = 0; n < count; n++) begin
            // alternate stretches with and without idling
            if (n % 20 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (pressure && n == count / 2) hold_go = 1;
            send(random_cmd());
        end
        tx_quiet = 0;
        rx_quiet = 0;
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_command = '0;
        i_entry_id = '0;
        i_due_time = '0;
        i_payload = '0;
        i_now_time = '0;
        i_source_id = '0;
        i_seq_id = '0;
        i_response_handle = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        sb.reset_state();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // disabled, identity zero: empty reports, rejected and accepted adds
        write_reg(tcd_pkg::CFG_ENABLED, 31'd0);
        write_reg(tcd_pkg::CFG_SCHED_ID, 31'd0);
        cmd(tcd_pkg::CMD_STATUS);
        cmd(tcd_pkg::CMD_LIST);
        cmd(tcd_pkg::CMD_ADD, 31'd5, 48'd10, 16'd0);
        cmd(tcd_pkg::CMD_ADD, 31'd0, 48'd10, 16'd3);
        cmd(tcd_pkg::CMD_ADD, 31'd5, 48'd0, 16'd3);
        cmd(tcd_pkg::CMD_ADD, 31'h7FFFFFFF, 48'hFFFFFFFFFFFF, 16'hFFFF);
        cmd(tcd_pkg::CMD_ADD, 31'h7FFFFFFF, 48'd7, 16'd1);
        cmd(tcd_pkg::CMD_ADD, 31'd5, 48'd10, 16'd3);
        cmd(tcd_pkg::CMD_TICK, '0, '0, '0, 48'hFFFFFFFFFFFF);
        cmd(CMD_UNKNOWN);
        cmd(tcd_pkg::CMD_DELETE, 31'd9);
        cmd(tcd_pkg::CMD_RESPONSE, '0, '0, '0, '0, 31'd1, 27'd1, 16'd9);
        cmd(tcd_pkg::CMD_LIST);
        cmd(tcd_pkg::CMD_FLUSH);
        drain();

        // enabled, identity at its maximum: full table, dispatch and completion
        write_reg(tcd_pkg::CFG_ENABLED, 31'd1);
        write_reg(tcd_pkg::CFG_SCHED_ID, 31'h7FFFFFFF);
        for (int i = 1; i <= ENTRIES; i++)
            cmd(tcd_pkg::CMD_ADD, 31'(i), (i == 2) ? 48'd20 : 48'(40 - i),
                16'(100 + i));
        cmd(tcd_pkg::CMD_ADD, 31'd99, 48'd1, 16'd1);
        cmd(tcd_pkg::CMD_TICK, '0, '0, '0, 48'd0);
        cmd(tcd_pkg::CMD_TICK, '0, '0, '0, 48'hFFFFFFFFFFFF);
        cmd(tcd_pkg::CMD_TICK, '0, '0, '0, 48'hFFFFFFFFFFFF);
        cmd(tcd_pkg::CMD_RESPONSE, '0, '0, '0, '0, 31'd0, 27'd2, 16'd5);
        cmd(tcd_pkg::CMD_RESPONSE, '0, '0, '0, '0, 31'h7FFFFFFF, 27'd100000000, 16'd5);
        cmd(tcd_pkg::CMD_RESPONSE, '0, '0, '0, '0, 31'h7FFFFFFF, 27'd2, 16'hFFFF);
        cmd(tcd_pkg::CMD_RESPONSE, '0, '0, '0, '0, 31'h7FFFFFFF, 27'd1, 16'h1234);
        cmd(tcd_pkg::CMD_STATUS);
        cmd(tcd_pkg::CMD_LIST);
        cmd(tcd_pkg::CMD_DELETE, 31'd3);
        cmd(tcd_pkg::CMD_STATUS);
        cmd(tcd_pkg::CMD_FLUSH);
        drain();

        random_phase(1'b1, 31'($urandom), 60, 1'b1);
        random_phase(1'b0, 31'd0, 40, 1'b0);
        random_phase(1'b1, 31'h7FFFFFFF, 60, 1'b0);
        random_phase(1'b1, 31'($urandom), 60, 1'b0);

        if (sb.expq.size() != 0) report("expected results never arrived");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
